### design/piecewise_linear_time_table_macros.svh
// assertion helpers used by the design file piecewise_linear_time_table.sv
`ifndef PIECEWISE_LINEAR_TIME_TABLE_MACROS_SVH
`define PIECEWISE_LINEAR_TIME_TABLE_MACROS_SVH

// plain invariant, checked at every edge outside reset
`define PTLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PTLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ptlt_pkg.sv
package ptlt_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefTimeBits   = 32;
  localparam int unsigned DefValueBits  = 32;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

endpackage

### design/ptlt_store.sv
module ptlt_store #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned VALUE_BITS  = 32,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [TIME_BITS-1:0]  wtime_i,
  input  logic [VALUE_BITS-1:0] wvalue_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [TIME_BITS-1:0]  rtime_o,
  output logic [VALUE_BITS-1:0] rvalue_o
);

  logic [TIME_BITS-1:0]  time_mem  [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i]  <= wtime_i;
      value_mem[waddr_i] <= wvalue_i;
    end
  end

  // registered read, data in the cycle after the address
  always_ff @(posedge clk_i) begin
    rtime_o  <= time_mem[raddr_i];
    rvalue_o <= value_mem[raddr_i];
  end

endmodule

### design/ptlt_muldiv.sv
module ptlt_muldiv #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TIME_BITS-1:0]  a_i,
  input  logic [TIME_BITS-1:0]  d_i,
  input  logic [VALUE_BITS-1:0] b_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] q_o
);

  localparam int unsigned NW = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  phase_q, phase_d;
  logic [NW-1:0]         cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [TIME_BITS-1:0]  a_q, a_d;
  logic [TIME_BITS-1:0]  d_q, d_d;
  logic [VALUE_BITS-1:0] b_q, b_d;
  logic [TIME_BITS:0]    r_q, r_d;
  logic [VALUE_BITS-1:0] q_q, q_d;

  logic [TIME_BITS:0]    x;
  logic                  ge;
  logic [VALUE_BITS-1:0] qbase;

  // floor(a*b/d) with a < d: per multiplier bit, a doubling step then an add step,
  // each followed by one conditional subtract of d
  always_comb begin
    if (phase_q) begin
      x     = r_q + (b_q[VALUE_BITS-1] ? {1'b0, a_q} : '0);
      qbase = q_q;
    end else begin
      x     = {r_q[TIME_BITS-1:0], 1'b0};
      qbase = {q_q[VALUE_BITS-2:0], 1'b0};
    end
    ge = (x >= {1'b0, d_q});
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    d_d     = d_q;
    b_d     = b_q;
    r_d     = r_q;
    q_d     = q_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = '0;
      a_d     = a_i;
      d_d     = d_i;
      b_d     = b_i;
      r_d     = '0;
      q_d     = '0;
    end else if (busy_q) begin
      r_d     = ge ? (x - {1'b0, d_q}) : x;
      q_d     = qbase + VALUE_BITS'(ge);
      phase_d = ~phase_q;
      if (phase_q) begin
        b_d   = {b_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(VALUE_BITS - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    d_q <= d_d;
    b_q <= b_d;
    r_q <= r_d;
    q_q <= q_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### design/piecewise_linear_time_table.sv
// Piecewise-linear time table. Rows of (time, value) are appended into a table of
// TABLE_DEPTH entries and a query interpolates the value at a given time between the
// cursor row and the row after it; times are unsigned and values signed fixed point.
// Clear, append and unused codes, and queries on fewer than two rows, are answered
// from the idle state and free the input on the next cycle unless an output stall
// holds the result. A query on two or more rows walks the cursor forward one row a
// cycle through the single read port of the table memory, and the multiply-divide
// is a shift-subtract unit that spends a doubling step and an add step on each
// value bit. Queries that clamp to a row value skip that unit. Every transaction
// gives exactly one result; the input is stalled while a query is in progress and
// while an undelivered result is held in the output register.
`include "piecewise_linear_time_table_macros.svh"

module piecewise_linear_time_table
  import ptlt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned TIME_BITS   = DefTimeBits,
  parameter int unsigned VALUE_BITS  = DefValueBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input transactions
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [TIME_BITS-1:0]         time_point_i,
  input  logic signed [VALUE_BITS-1:0] row_value_i,
  // result transactions
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] result_value_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned VW = VALUE_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_ADDR = 3'd1;  // address of cursor row out to the memory
  localparam logic [2:0] S_INI  = 3'd2;  // cursor row arrives
  localparam logic [2:0] S_NEXT = 3'd3;  // following row arrives, walk or stop
  localparam logic [2:0] S_DEC  = 3'd4;  // clamp or start the multiply-divide
  localparam logic [2:0] S_MUL  = 3'd5;  // multiply-divide running
  localparam logic [2:0] S_DONE = 3'd6;  // waiting for the output register

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] rowcnt_q, rowcnt_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic          out_valid_q, out_valid_d;

  // query working registers
  logic [AW-1:0] c_q, c_d;
  logic [TW-1:0] t_q, t_d;
  logic [TW-1:0] tini_q, tini_d;
  logic [TW-1:0] tnext_q, tnext_d;
  logic [VW-1:0] vini_q, vini_d;
  logic [VW-1:0] vnext_q, vnext_d;
  logic [VW:0]   dv_q, dv_d;
  logic [VW-1:0] res_q, res_d;
  logic [VW-1:0] out_res_q, out_res_d;
  logic [1:0]    sts_q, sts_d;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [TW-1:0] rtime;
  logic [VW-1:0] rvalue;

  // multiply-divide unit
  logic          md_start;
  logic [TW-1:0] md_a, md_d;
  logic [VW-1:0] md_b;
  logic          md_done;
  logic [VW-1:0] md_q;

  logic          accept;
  logic          out_free;
  logic          full;
  logic [CW-1:0] max_c;
  logic [AW-1:0] c_start;
  logic          advance;
  logic [VW:0]   mag_full;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (rowcnt_q >= CW'(TABLE_DEPTH));

  // cursor limited to the last pair before use
  assign max_c   = rowcnt_q - CW'(2);
  assign c_start = (CW'(cursor_q) > max_c) ? max_c[AW-1:0] : cursor_q;

  // walk on while the next time is below the query and a row stays after the cursor
  assign advance = (rtime < t_q) && ((CW'(c_q) + CW'(2)) < rowcnt_q);

  assign mem_we   = accept && (command_i == CMD_APPEND) && !full;
  assign mag_full = dv_q[VW] ? (~dv_q + (VW + 1)'(1)) : dv_q;

  always_comb begin
    case (state_q)
      S_ADDR:  mem_raddr = c_q;
      S_INI:   mem_raddr = c_q + AW'(1);
      S_NEXT:  mem_raddr = advance ? (c_q + AW'(2)) : (c_q + AW'(1));
      default: mem_raddr = c_q;
    endcase
  end

  assign md_a = t_q - tini_q;
  assign md_d = tnext_q - tini_q;
  assign md_b = mag_full[VW-1:0];

  always_comb begin
    state_d     = state_q;
    rowcnt_d    = rowcnt_q;
    cursor_d    = cursor_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    sts_d       = sts_q;
    c_d         = c_q;
    t_d         = t_q;
    tini_d      = tini_q;
    tnext_d     = tnext_q;
    vini_d      = vini_q;
    vnext_d     = vnext_q;
    dv_d        = dv_q;
    res_d       = res_q;
    md_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // commands answered from the idle state give zero with a status
          out_res_d = '0;
          sts_d     = ST_OK;
          case (command_i)
            CMD_CLEAR: begin
              rowcnt_d    = '0;
              cursor_d    = '0;
              out_valid_d = 1'b1;
            end
            CMD_APPEND: begin
              if (full) begin
                sts_d = ST_FULL;
              end else begin
                rowcnt_d = rowcnt_q + CW'(1);
              end
              out_valid_d = 1'b1;
            end
            CMD_QUERY: begin
              if (rowcnt_q < CW'(2)) begin
                sts_d       = ST_SHORT;
                out_valid_d = 1'b1;
              end else begin
                c_d     = c_start;
                t_d     = time_point_i;
                state_d = S_ADDR;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_ADDR: begin
        state_d = S_INI;
      end
      S_INI: begin
        tini_d  = rtime;
        vini_d  = rvalue;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (advance) begin
          c_d    = c_q + AW'(1);
          tini_d = rtime;
          vini_d = rvalue;
        end else begin
          cursor_d = c_q;
          tnext_d  = rtime;
          vnext_d  = rvalue;
          dv_d     = {rvalue[VW-1], rvalue} - {vini_q[VW-1], vini_q};
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (t_q <= tini_q) begin
          res_d   = vini_q;
          state_d = S_DONE;
        end else if (t_q >= tnext_q) begin
          res_d   = vnext_q;
          state_d = S_DONE;
        end else begin
          md_start = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (md_done) begin
          // quotient truncated toward zero, applied with the sign of the slope
          res_d   = dv_q[VW] ? (vini_q - md_q) : (vini_q + md_q);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_res_d   = res_q;
          sts_d       = ST_OK;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rowcnt_q    <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rowcnt_q    <= rowcnt_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    t_q       <= t_d;
    tini_q    <= tini_d;
    tnext_q   <= tnext_d;
    vini_q    <= vini_d;
    vnext_q   <= vnext_d;
    dv_q      <= dv_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
    sts_q     <= sts_d;
  end

  ptlt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (rowcnt_q[AW-1:0]),
    .wtime_i  (time_point_i),
    .wvalue_i (row_value_i),
    .raddr_i  (mem_raddr),
    .rtime_o  (rtime),
    .rvalue_o (rvalue)
  );

  ptlt_muldiv #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .d_i     (md_d),
    .b_i     (md_b),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = $signed(out_res_q);
  assign status_o       = sts_q;

  // cursor always names a lower row with one row after it
  `PTLT_ASSERT_IMPL(a_cursor_range, rowcnt_q >= CW'(2), CW'(cursor_q) <= max_c, "cursor past last pair")
  `PTLT_ASSERT(a_rowcnt_bound, rowcnt_q <= CW'(TABLE_DEPTH), "row count beyond table depth")
  `PTLT_ASSERT_IMPL(a_done_in_mul, md_done, state_q == S_MUL, "divider finished outside its state")
  `PTLT_ASSERT_IMPL(a_flag_zero, out_valid_q && (sts_q != ST_OK), out_res_q == '0, "flagged result not zero")
  `PTLT_ASSERT_NEXT(a_query_starts, accept && (command_i == CMD_QUERY) && (rowcnt_q >= CW'(2)), state_q == S_ADDR, "query did not start the walk")

endmodule

### test/tb_piecewise_linear_time_table.sv
`timescale 1ns / 100ps

module tb_piecewise_linear_time_table;
  import ptlt_pkg::*;

  // table geometry of the default build
  localparam int unsigned TableDepth = DefTableDepth;
  localparam int unsigned TimeBits   = DefTimeBits;
  localparam int unsigned ValueBits  = DefValueBits;

  // command code that the block has to ignore
  localparam logic [1:0] CmdUnused = 2'd3;

  // run control
  localparam int unsigned StallLimit = 8000;   // cycles with no transaction on either side
  localparam int unsigned TailCycles = 200;    // quiet time after the last result
  localparam int unsigned HoldCycles = 300;    // long output hold-off
  localparam int unsigned RandomPerPhase = 145;
  localparam int unsigned WalkRows   = 120;    // rows in the long cursor walk

  // one result of the block
  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic [1:0]                  status;
  } table_result_t;

  // clock, reset and block inputs, all known from time zero
  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic [1:0]                   command_i    = CMD_CLEAR;
  logic [TimeBits-1:0]          time_point_i = '0;
  logic signed [ValueBits-1:0]  row_value_i  = '0;
  logic                         out_stall_i  = 1'b0;

  logic                         in_stall_o;
  logic                         out_valid_o;
  logic signed [ValueBits-1:0]  result_value_o;
  logic [1:0]                   status_o;

  // mirror of the table used to work out expected results
  logic [TimeBits-1:0]  time_rows  [TableDepth];
  logic [ValueBits-1:0] value_rows [TableDepth];
  int unsigned          rows_held;
  int unsigned          lower_row;

  // results still owed by the block, oldest first
  table_result_t pending_results[$];

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // set by a test to make the receiver hold off for that many cycles
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  // bookkeeping
  int unsigned error_count   = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned interp_count  = 0;
  int unsigned full_count    = 0;
  int unsigned short_count   = 0;
  int unsigned quiet_cycles  = 0;

  piecewise_linear_time_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .time_point_i   (time_point_i),
    .row_value_i    (row_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // apply one command to the mirrored table and return the result it should give
  function automatic table_result_t apply_command(logic [1:0] cmd, logic [TimeBits-1:0] tp,
                                                  logic [ValueBits-1:0] rv);
    table_result_t        res;
    int unsigned          c;
    logic [TimeBits-1:0]  t_lo;
    logic [TimeBits-1:0]  t_hi;
    logic signed [32:0]   v_lo;
    logic signed [32:0]   v_hi;
    logic signed [32:0]   dv;
    logic [32:0]          mag;
    logic [63:0]          prod;
    logic [63:0]          quot;
    logic [32:0]          sum;
    logic                 neg;
    res.value  = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        // stores keep their contents, only the count and cursor go back
        rows_held = 0;
        lower_row = 0;
      end
      CMD_APPEND: begin
        if (rows_held >= TableDepth) begin
          res.status = ST_FULL;
          full_count++;
        end else begin
          time_rows[rows_held]  = tp;
          value_rows[rows_held] = rv;
          rows_held++;
        end
      end
      CMD_QUERY: begin
        if (rows_held < 2) begin
          res.status = ST_SHORT;
          short_count++;
        end else begin
          c = lower_row;
          if (c > rows_held - 2) c = rows_held - 2;
          t_lo = time_rows[c];
          t_hi = time_rows[c+1];
          // walk forward only, always keeping one row above the cursor
          while (t_hi < tp && c + 2 < rows_held) begin
            c++;
            t_lo = t_hi;
            t_hi = time_rows[c+1];
          end
          lower_row = c;
          if (tp <= t_lo) begin
            res.value = value_rows[c];
          end else if (tp >= t_hi) begin
            res.value = value_rows[c+1];
          end else begin
            // strictly inside the segment, divisor is nonzero
            v_lo = {value_rows[c][ValueBits-1], value_rows[c]};
            v_hi = {value_rows[c+1][ValueBits-1], value_rows[c+1]};
            dv   = v_hi - v_lo;
            neg  = dv[32];
            mag  = neg ? -dv : dv;
            prod = {32'd0, tp - t_lo} * {31'd0, mag};
            quot = prod / {32'd0, t_hi - t_lo};
            sum  = neg ? v_lo - quot[32:0] : v_lo + quot[32:0];
            res.value = sum[ValueBits-1:0];
            interp_count++;
          end
        end
      end
      default: begin
        // unused code, no effect
      end
    endcase
    return res;
  endfunction

  // row values biased toward the extremes
  function automatic logic [ValueBits-1:0] random_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // offer one transaction and hold it until the block takes it
  task automatic send_item(input logic [1:0] cmd, input logic [TimeBits-1:0] tp,
                           input logic [ValueBits-1:0] rv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    time_point_i <= tp;
    row_value_i  <= rv;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge
    pending_results.push_back(apply_command(cmd, tp, rv));
    sent_count++;
  endtask

  // stop offering and let every owed result come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // a table of sorted rows followed by queries of rising time
  task automatic send_sorted_sequence(input int unsigned n_rows, input int unsigned n_queries,
                                      input logic [31:0] step_max);
    logic [63:0] t_acc;
    logic [63:0] first_t;
    logic [63:0] last_t;
    logic [63:0] q_step;
    int unsigned i;
    send_item(CMD_CLEAR, $urandom, $urandom);
    t_acc   = $urandom_range(0, step_max);
    first_t = t_acc;
    for (i = 0; i < n_rows; i++) begin
      send_item(CMD_APPEND, t_acc[31:0], random_value());
      last_t = t_acc;
      t_acc  = t_acc + $urandom_range(0, step_max);
      if (t_acc > 64'hFFFF_FFFF) t_acc = 64'hFFFF_FFFF;
    end
    // start a little below the first row and finish past the last
    t_acc  = (first_t > 64) ? first_t - $urandom_range(0, 64) : 64'd0;
    q_step = ((last_t - first_t) / n_queries) * 2 + 2;
    if (q_step > 64'hFFFF_FFFF) q_step = 64'hFFFF_FFFF;
    for (i = 0; i < n_queries; i++) begin
      if ($urandom_range(9) == 0) begin
        // out of order query, cursor must not move back
        send_item(CMD_QUERY, $urandom, $urandom);
      end else begin
        send_item(CMD_QUERY, t_acc[31:0], $urandom);
        t_acc = t_acc + $urandom_range(0, q_step[31:0]);
        if (t_acc > 64'hFFFF_FFFF) t_acc = 64'hFFFF_FFFF;
      end
    end
  endtask

  // empty and single-row tables, unused code, all-ones fields
  task automatic test_short_table();
    send_item(CMD_QUERY, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  // clamps at both ends and full-range interpolation in both directions
  task automatic test_clamp_and_interpolate();
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    send_item(CMD_APPEND, 32'h0000_0000, 32'h8000_0000);
    send_item(CMD_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(CMD_QUERY, 32'h0000_0000, 32'h0);
    send_item(CMD_QUERY, 32'h0000_0001, 32'h0);
    send_item(CMD_QUERY, 32'h8000_0000, 32'h0);
    send_item(CMD_QUERY, 32'hFFFF_FFFE, 32'h0);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
    // falling slope
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    send_item(CMD_APPEND, 32'd100, 32'h7FFF_FFFF);
    send_item(CMD_APPEND, 32'd200, 32'h8000_0000);
    send_item(CMD_QUERY, 32'd150, 32'h0);
    send_item(CMD_QUERY, 32'd101, 32'h0);
    send_item(CMD_QUERY, 32'd199, 32'h0);
    wait_for_results();
  endtask

  // rows out of time order, repeated times, query behind the cursor
  task automatic test_unsorted_rows();
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    send_item(CMD_APPEND, 32'd500, 32'd1000);
    send_item(CMD_APPEND, 32'd400, -32'sd1000);
    send_item(CMD_APPEND, 32'd400, 32'd5);
    send_item(CMD_QUERY, 32'd450, 32'h0);
    send_item(CMD_QUERY, 32'd600, 32'h0);
    send_item(CMD_QUERY, 32'd0, 32'h0);
    wait_for_results();
  endtask

  // long table spread over the whole time range, cursor walked to the last pair
  task automatic test_long_walk();
    int unsigned i;
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    for (i = 0; i < WalkRows; i++)
      send_item(CMD_APPEND, i * 32'd35_000_000 + $urandom_range(0, 30_000_000), random_value());
    send_item(CMD_QUERY, 32'h0, 32'h0);
    send_item(CMD_QUERY, 32'd2_000_000_000 + $urandom_range(0, 1_000_000), 32'h0);
    send_item(CMD_QUERY, 32'd4_090_000_000 + $urandom_range(0, 2_000_000), 32'h0);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
    // cursor now sits on the last pair
    send_item(CMD_QUERY, 32'h0, 32'h0);
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    send_item(CMD_QUERY, $urandom, $urandom);
    wait_for_results();
  endtask

  // mostly well-formed tables and queries, the rest random noise
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent_here;
    int unsigned n_rows;
    int unsigned n_q;
    int unsigned n_noise;
    int unsigned i;
    logic [31:0] step_max;
    sent_here = 0;
    while (sent_here < n_items) begin
      if ($urandom_range(99) < 80) begin
        n_rows   = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 8);
        n_q      = $urandom_range(1, 10);
        step_max = ($urandom_range(3) == 0) ? 32'd1000 : 32'hFFFF_FFFF / (n_rows + 1);
        send_sorted_sequence(n_rows, n_q, step_max);
        sent_here += 1 + n_rows + n_q;
      end else begin
        n_noise = $urandom_range(1, 6);
        for (i = 0; i < n_noise; i++)
          send_item(2'($urandom_range(3)), $urandom, $urandom);
        sent_here += n_noise;
      end
    end
    wait_for_results();
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_output_hold_off();
    hold_request = HoldCycles;
    send_sorted_sequence(6, 18, 32'd50_000);
    wait_for_results();
  endtask

  // receiver side: random stall, or a long counted hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else if (hold_request > 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker, one result transaction against the oldest expectation
  always @(posedge clk_i) begin
    table_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value %h status %0d",
                                  result_value_o, status_o));
      end else begin
        exp_res = pending_results.pop_front();
        checked_count++;
        if (result_value_o !== exp_res.value)
          report_mismatch($sformatf("result_value %h, expected %h",
                                    result_value_o, exp_res.value));
        if (status_o !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, exp_res.status));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("tb_piecewise_linear_time_table: errors");
        $finish;
      end
    end
  end

  initial begin
    rows_held = 0;
    lower_row = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles a little, receiver a lot
    send_idle_pct = 8;
    recv_idle_pct = 48;
    test_short_table();
    test_clamp_and_interpolate();
    test_unsorted_rows();
    test_long_walk();
    test_output_hold_off();
    test_random_traffic(RandomPerPhase);

    // the other way round
    send_idle_pct = 48;
    recv_idle_pct = 8;
    test_random_traffic(RandomPerPhase);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_hold_off();
    test_random_traffic(RandomPerPhase);

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d transactions sent, %0d results checked, %0d interpolated, %0d full, %0d short",
             sent_count, checked_count, interp_count, full_count, short_count);
    $display("covered clear, append, short table, unused code, clamps, long cursor walks");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_piecewise_linear_time_table: clean");
    end else begin
      $display("tb_piecewise_linear_time_table: errors");
    end
    $finish;
  end

endmodule
